// File: rtl/core/lipw_pkg.sv
package lipw_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 9;

    // Field widths.
    localparam int CMD_W = 32;
    localparam int PW_W  = 16;

    // Datapath widths: a product of a width and a command difference, the
    // rounding numerator, and the divider remainder.
    localparam int PROD_W = CMD_W + PW_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int REM_W  = CMD_W + 1;
    localparam int CNT_W  = $clog2(PW_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_WIDTH = 1'd1;

    localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET  = 9'd2;
    localparam logic [PW_W-1:0]  NEUTRAL_WIDTH_RESET = 16'd1500;

    // Word modes.
    localparam logic MODE_WRITE   = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

endpackage

// File: rtl/core/lut_interpolated_pulse_width.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  mode, entry_index, entry_command, entry_width, command
// m_        out        m_valid / m_ready  pulse_width
// cfg_      in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
// A table write leaves the block idle, so it stays ready for the next word. A zero
// command goes straight to the done state, a command at or below the first breakpoint
// ends after the low check, and one at or above the last breakpoint after the high check.
// Any other command walks the table, then forms differences, products, sum and quotient:
// one shared multiplier runs twice and a restoring divider gives one quotient bit a cycle.
// Reset is synchronous and active low; the table RAM is not cleared.
// A finished result waits until the output register is free, so a stalled sink adds its
// stall to the item's time, and the block takes no new word meanwhile.
module lut_interpolated_pulse_width
    import lipw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [ADDR_W-1:0]     s_entry_index,
    input  logic signed [CMD_W-1:0] s_entry_command,
    input  logic [PW_W-1:0]       s_entry_width,
    input  logic signed [CMD_W-1:0] s_command,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PW_W-1:0]       m_pulse_width,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LO_CHK,
        S_HI_CHK,
        S_WALK,
        S_DIFF,
        S_MUL_A,
        S_MUL_B,
        S_ADD,
        S_NUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic [CMD_W-1:0]      c_reg, c_next;
    logic [CMD_W-1:0]      x0_reg, x0_next, x1_reg, x1_next;
    logic [PW_W-1:0]       y0_reg, y0_next, y1_reg, y1_next;
    logic [CMD_W-1:0]      t_reg, t_next, e_reg, e_next, d_reg, d_next;
    logic [PROD_W-1:0]     prod_reg, prod_next, acc_reg, acc_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [PW_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PW_W-1:0]       res_reg, res_next;
    logic [PW_W-1:0]       pw_reg, pw_next;
    logic                  m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]      tl_reg, tl_next;
    logic [PW_W-1:0]       nw_reg, nw_next;

    logic                  s_accept;
    logic                  ram_we;
    logic [CMD_W-1:0]      bp_rdata;
    logic [PW_W-1:0]       w_rdata;
    logic [ADDR_W-1:0]     last_idx;
    logic [PW_W-1:0]       mul_a;
    logic [CMD_W-1:0]      mul_b;
    logic [PROD_W-1:0]     mul_out;
    logic [NUM_W-1:0]      num;
    logic [REM_W:0]        rem_shift;
    logic [REM_W:0]        divisor;
    logic                  div_bit;
    logic                  out_free;

    assign s_ready       = (state_reg == S_IDLE);
    assign s_accept      = s_valid && s_ready;
    assign ram_we        = s_accept && (s_mode == MODE_WRITE);
    assign m_valid       = m_valid_reg;
    assign m_pulse_width = pw_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // Breakpoint and width tables; the read address follows the next index so
    // that the read data always belongs to the current index.
    lipw_ram #(.WIDTH(CMD_W), .DEPTH(TABLE_DEPTH)) u_bp_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (s_entry_index),
        .wdata (s_entry_command),
        .raddr (idx_next),
        .rdata (bp_rdata)
    );

    lipw_ram #(.WIDTH(PW_W), .DEPTH(TABLE_DEPTH)) u_w_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (s_entry_index),
        .wdata (s_entry_width),
        .raddr (idx_next),
        .rdata (w_rdata)
    );

    // Last index in use, with the table length held between two and the depth.
    always_comb begin
        if (tl_reg < LEN_W'(2)) begin
            last_idx = ADDR_W'(1);
        end else if (tl_reg > LEN_W'(TABLE_DEPTH)) begin
            last_idx = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            last_idx = ADDR_W'(tl_reg - LEN_W'(1));
        end
    end

    // Shared multiplier: the lower width times the distance above the command,
    // then the upper width times the distance below it.
    assign mul_a   = (state_reg == S_MUL_A) ? y0_reg : y1_reg;
    assign mul_b   = (state_reg == S_MUL_A) ? e_reg : t_reg;
    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Rounding numerator 2v + d, divided by 2d below.
    assign num     = {1'b0, acc_reg, 1'b0} + NUM_W'(d_reg);
    assign divisor = {1'b0, d_reg, 1'b0};

    // One restoring division step.
    assign rem_shift = {rem_reg, quo_reg[PW_W-1]};
    assign div_bit   = (rem_shift >= divisor);

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        c_next       = c_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        y0_next      = y0_reg;
        y1_next      = y1_reg;
        t_next       = t_reg;
        e_next       = e_reg;
        d_next       = d_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        pw_next      = pw_reg;
        m_valid_next = m_valid_reg;
        tl_next      = tl_reg;
        nw_next      = nw_reg;

        // The result register empties when the sink takes the word.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TABLE_LENGTH:  tl_next = cfg_wdata[LEN_W-1:0];
                CFG_NEUTRAL_WIDTH: nw_next = cfg_wdata[PW_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_mode == MODE_CONVERT)) begin
                    c_next = s_command;
                    if (s_command == '0) begin
                        res_next   = nw_reg;
                        state_next = S_DONE;
                    end else begin
                        idx_next   = '0;
                        state_next = S_LO_CHK;
                    end
                end
            end

            // Saturation at the first breakpoint.
            S_LO_CHK: begin
                x0_next = bp_rdata;
                y0_next = w_rdata;
                if ($signed(c_reg) <= $signed(bp_rdata)) begin
                    res_next   = w_rdata;
                    state_next = S_DONE;
                end else begin
                    idx_next   = last_idx;
                    state_next = S_HI_CHK;
                end
            end

            // Saturation at the last breakpoint in use.
            S_HI_CHK: begin
                if ($signed(c_reg) >= $signed(bp_rdata)) begin
                    res_next   = w_rdata;
                    state_next = S_DONE;
                end else begin
                    idx_next   = ADDR_W'(1);
                    state_next = S_WALK;
                end
            end

            // Walk up to the first breakpoint at or above the command.
            S_WALK: begin
                if ((idx_reg < last_idx) && ($signed(c_reg) > $signed(bp_rdata))) begin
                    x0_next  = bp_rdata;
                    y0_next  = w_rdata;
                    idx_next = idx_reg + ADDR_W'(1);
                end else begin
                    x1_next    = bp_rdata;
                    y1_next    = w_rdata;
                    state_next = S_DIFF;
                end
            end

            // The differences all lie in zero to 2^32-1, so a wrapping
            // subtraction gives them exactly.
            S_DIFF: begin
                t_next     = c_reg - x0_reg;
                e_next     = x1_reg - c_reg;
                d_next     = x1_reg - x0_reg;
                state_next = S_MUL_A;
            end

            S_MUL_A: begin
                prod_next  = mul_out;
                state_next = S_MUL_B;
            end

            S_MUL_B: begin
                acc_next   = prod_reg;
                prod_next  = mul_out;
                state_next = S_ADD;
            end

            S_ADD: begin
                acc_next   = acc_reg + prod_reg;
                state_next = S_NUM;
            end

            // The quotient fits in the width field, so the upper part of the
            // numerator already lies below the divisor.
            S_NUM: begin
                rem_next   = num[NUM_W-2:PW_W];
                quo_next   = num[PW_W-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end

            S_DIV: begin
                if (div_bit) begin
                    rem_next = REM_W'(rem_shift - divisor);
                end else begin
                    rem_next = rem_shift[REM_W-1:0];
                end
                quo_next = {quo_reg[PW_W-2:0], div_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PW_W - 1)) begin
                    res_next   = {quo_reg[PW_W-2:0], div_bit};
                    state_next = S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (out_free) begin
                    pw_next      = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State, configuration, datapath and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            tl_reg      <= TABLE_LENGTH_RESET;
            nw_reg      <= NEUTRAL_WIDTH_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tl_reg      <= tl_next;
            nw_reg      <= nw_next;
        end
        idx_reg  <= idx_next;
        c_reg    <= c_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        t_reg    <= t_next;
        e_reg    <= e_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        pw_reg   <= pw_next;
    end

endmodule

// File: rtl/core/lipw_ram.sv
module lipw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/lipw_checker.sv
module lipw_checker
    import lipw_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_mode,
    input  logic signed [CMD_W-1:0] s_command,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [PW_W-1:0]         m_pulse_width
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pulse_width))
        else $error("result word changed or dropped while stalled");

    // A conversion occupies the block for at least the following cycle.
    a_convert_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_CONVERT) |=> !s_ready)
        else $error("block ready straight after taking a conversion");

    // A table write leaves the block ready for the next word.
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_WRITE) |=> s_ready)
        else $error("block not ready after a table write");

    // A zero command taken with an empty output register passes through the
    // done state and then raises the result valid.
    a_zero_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_CONVERT) && (s_command == '0) && !m_valid
        |=> ##1 m_valid)
        else $error("zero command result late");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lut_interpolated_pulse_width lipw_checker u_lipw_checker (.*);

// File: verif/lut_interpolated_pulse_width_tb.sv
module lut_interpolated_pulse_width_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lipw_pkg::*;

    localparam int     SETTLE_CYCLES = 300;
    localparam longint TIMEOUT_NS    = 25_000_000;
    localparam int     CMD_MIN       = 32'sh8000_0000;
    localparam int     CMD_MAX       = 32'sh7FFF_FFFF;
    localparam int     Q_ONE         = 1 << 16;

    typedef struct packed {
        logic                    mode;
        logic [ADDR_W-1:0]       entry_index;
        logic signed [CMD_W-1:0] entry_command;
        logic [PW_W-1:0]         entry_width;
        logic signed [CMD_W-1:0] command;
    } lut_word_t;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic                    s_mode          = MODE_WRITE;
    logic [ADDR_W-1:0]       s_entry_index   = '0;
    logic signed [CMD_W-1:0] s_entry_command = '0;
    logic [PW_W-1:0]         s_entry_width   = '0;
    logic signed [CMD_W-1:0] s_command       = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [PW_W-1:0]         m_pulse_width;
    logic                    cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index       = CFG_TABLE_LENGTH;
    logic [CFG_DATA_W-1:0]   cfg_wdata       = '0;

    // Mirror of the block's table and registers, updated as words are accepted.
    logic signed [CMD_W-1:0] bp_tab [TABLE_DEPTH];
    logic [PW_W-1:0]         pw_tab [TABLE_DEPTH];
    logic [LEN_W-1:0]        len_reg     = TABLE_LENGTH_RESET;
    logic [PW_W-1:0]         neutral_reg = NEUTRAL_WIDTH_RESET;

    // What the stimulus has queued so far, used to aim commands at the table.
    int plan_bp      [TABLE_DEPTH];
    bit plan_written [TABLE_DEPTH];
    int unsigned plan_len = 2;

    lut_word_t       pending_q[$];
    logic [PW_W-1:0] widths_due_q[$];
    lut_word_t       held_word;
    logic [PW_W-1:0] width_due;
    int              words_in_flight = 0;
    int              fail_count      = 0;
    int              send_idle_pct   = 0;
    int              recv_stall_pct  = 0;

    lut_interpolated_pulse_width u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_entry_index   (s_entry_index),
        .s_entry_command (s_entry_command),
        .s_entry_width   (s_entry_width),
        .s_command       (s_command),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pulse_width   (m_pulse_width),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Entries in use, with out-of-range lengths pulled back to the limits.
    function automatic int unsigned active_entries(logic [LEN_W-1:0] len);
        if (len < 2) return 2;
        if (len > TABLE_DEPTH) return TABLE_DEPTH;
        return len;
    endfunction

    // Pulse width for a command: neutral at zero, saturated at the ends, and
    // otherwise interpolated between the bracketing pair, rounded half up.
    function automatic logic [PW_W-1:0] lookup_width(logic signed [CMD_W-1:0] c);
        int unsigned n;
        int unsigned i;
        longint      x0, x1, y0, y1, span, num, q;
        n = active_entries(len_reg);
        if (c == 0) return neutral_reg;
        if (c <= bp_tab[0]) return pw_tab[0];
        if (c >= bp_tab[n-1]) return pw_tab[n-1];
        i = 1;
        while (i < n - 1 && c > bp_tab[i]) i++;
        x0   = bp_tab[i-1];
        x1   = bp_tab[i];
        y0   = pw_tab[i-1];
        y1   = pw_tab[i];
        span = x1 - x0;
        num  = y0 * span + (y1 - y0) * (longint'(c) - x0);
        if (num < 0) num = 0;
        q = (2 * num + span) / (2 * span);
        if (q > 65535) q = 65535;
        return q[PW_W-1:0];
    endfunction

    // Apply one accepted word to the mirror, or record the width it must give.
    function automatic void absorb_word(lut_word_t w);
        if (w.mode == MODE_WRITE) begin
            bp_tab[w.entry_index] = w.entry_command;
            pw_tab[w.entry_index] = w.entry_width;
        end else begin
            widths_due_q = {widths_due_q, lookup_width(w.command)};
        end
    endfunction

    function automatic int sat32(longint v);
        if (v > CMD_MAX) return CMD_MAX;
        if (v < CMD_MIN) return CMD_MIN;
        return int'(v);
    endfunction

    task automatic push_write(int unsigned idx, int bp, int unsigned wd);
        lut_word_t w;
        w.mode          = MODE_WRITE;
        w.entry_index   = idx[ADDR_W-1:0];
        w.entry_command = bp;
        w.entry_width   = wd[PW_W-1:0];
        w.command       = $urandom;
        pending_q       = {pending_q, w};
        words_in_flight++;
        plan_bp[idx]      = bp;
        plan_written[idx] = 1'b1;
    endtask

    task automatic push_convert(int cmd);
        lut_word_t w;
        w.mode          = MODE_CONVERT;
        w.entry_index   = ADDR_W'($urandom);
        w.entry_command = $urandom;
        w.entry_width   = PW_W'($urandom);
        w.command       = cmd;
        pending_q       = {pending_q, w};
        words_in_flight++;
    endtask

    // Wait until every word is taken and every width returned, then let the
    // block settle before touching its registers.
    task automatic wait_idle();
        do @(negedge aclk);
        while (words_in_flight != 0 || widths_due_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TABLE_LENGTH) begin
            len_reg = data[LEN_W-1:0];
        end else begin
            neutral_reg = data;
        end
    endtask

    // Fill entries 0 to n-1 in a shuffled order, breakpoints sorted or not.
    task automatic load_table(int unsigned n, bit sorted, bit wide);
        int          vals  [TABLE_DEPTH];
        int unsigned order [TABLE_DEPTH];
        int          t;
        int unsigned j, u;
        for (int k = 0; k < n; k++) begin
            vals[k]  = wide ? int'($urandom) : int'($urandom_range(400000)) - 200000;
            order[k] = k;
        end
        if (sorted) begin
            for (int k = 1; k < n; k++) begin
                t = vals[k];
                j = k;
                while (j > 0 && vals[j-1] > t) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = t;
            end
        end
        for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            u        = order[k];
            order[k] = order[j];
            order[j] = u;
        end
        for (int k = 0; k < n; k++) begin
            push_write(order[k], vals[order[k]], $urandom);
        end
    endtask

    // Commands aimed at zero, the ends, the breakpoints and the gaps between
    // them, with stray writes beyond the table mixed in.
    task automatic queue_conversions(int count);
        int unsigned n;
        int          k;
        int          pick;
        longint      lo, hi;
        n = plan_len;
        for (int c = 0; c < count; c++) begin
            if (n < TABLE_DEPTH && $urandom_range(99) < 10) begin
                push_write($urandom_range(TABLE_DEPTH - 1, n), $urandom, $urandom);
            end
            pick = $urandom_range(99);
            k    = $urandom_range(n - 2, 0);
            lo   = plan_bp[k];
            hi   = plan_bp[k+1];
            if (pick < 8) begin
                push_convert(0);
            end else if (pick < 16) begin
                push_convert(sat32(longint'(plan_bp[0]) - longint'($urandom_range(5000))));
            end else if (pick < 24) begin
                push_convert(sat32(longint'(plan_bp[n-1]) + longint'($urandom_range(5000))));
            end else if (pick < 40) begin
                push_convert(plan_bp[$urandom_range(n - 1)]);
            end else if (pick < 85 && hi > lo) begin
                push_convert(int'(lo + longint'($urandom) % (hi - lo + 1)));
            end else begin
                push_convert($urandom);
            end
        end
    endtask

    task automatic run_phase(logic [LEN_W-1:0] len_val, logic [PW_W-1:0] neutral,
                             int conversions, bit fresh, bit sorted, bit wide,
                             int send_pct, int stall_pct);
        int unsigned           n;
        logic [CFG_DATA_W-1:0] len_word;
        wait_idle();
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        // Upper bits of the length write carry junk that the block must ignore.
        len_word              = CFG_DATA_W'($urandom);
        len_word[LEN_W-1:0]   = len_val;
        write_register(CFG_TABLE_LENGTH, len_word);
        write_register(CFG_NEUTRAL_WIDTH, neutral);
        n        = active_entries(len_val);
        plan_len = n;
        if (fresh) begin
            load_table(n, sorted, wide);
        end else begin
            for (int k = 0; k < n; k++) begin
                if (!plan_written[k]) push_write(k, $urandom, $urandom);
            end
            repeat (8) push_write($urandom_range(n - 1), $urandom, $urandom);
        end
        queue_conversions(conversions);
    endtask

    // Driver: present the next pending word once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_word(held_word);
                words_in_flight--;
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_word = pending_q.pop_front();
                    s_mode          <= held_word.mode;
                    s_entry_index   <= held_word.entry_index;
                    s_entry_command <= held_word.entry_command;
                    s_entry_width   <= held_word.entry_width;
                    s_command       <= held_word.command;
                    s_valid         <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each returned width against the oldest one due.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (widths_due_q.size() == 0) begin
                    $error("pulse_width word %0d arrived with none expected", m_pulse_width);
                    fail_count++;
                end else begin
                    width_due = widths_due_q.pop_front();
                    if (m_pulse_width !== width_due) begin
                        $error("pulse_width mismatch: expected %0d, actual %0d",
                               width_due, m_pulse_width);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Widest possible pair under the reset length: zero, both ends, and
        // interpolation across the full command range.
        push_write(0, CMD_MIN, 0);
        push_write(1, CMD_MAX, 16'hFFFF);
        push_convert(0);
        push_convert(CMD_MIN);
        push_convert(CMD_MAX);
        push_convert(1);
        push_convert(-1);
        // The last index is beyond the table in use and must not disturb it.
        push_write(TABLE_DEPTH - 1, CMD_MAX, 12345);
        // A typical pair: exact breakpoints and one step inside each end.
        push_write(0, -1000 * Q_ONE, 1000);
        push_write(1, 1000 * Q_ONE, 2000);
        push_convert(500 * Q_ONE);
        push_convert(-1000 * Q_ONE);
        push_convert(1000 * Q_ONE);
        push_convert(-1000 * Q_ONE + 1);
        push_convert(1000 * Q_ONE - 1);
        // Breakpoints in descending order with falling widths.
        push_write(0, 100 * Q_ONE, 3000);
        push_write(1, 50 * Q_ONE, 100);
        push_convert(75 * Q_ONE);
        push_convert(200 * Q_ONE);
        push_convert(10 * Q_ONE);
        // An exact half must round up.
        push_write(0, 0, 0);
        push_write(1, 2, 1);
        push_convert(1);

        run_phase(9'd0,   16'd0,           20, 1'b1, 1'b1, 1'b1, 46, 0);
        run_phase(9'd3,   16'hFFFF,        20, 1'b1, 1'b1, 1'b0, 0, 46);
        run_phase(9'd511, PW_W'($urandom), 25, 1'b1, 1'b1, 1'b0, 15, 15);
        run_phase(9'd8,   PW_W'($urandom), 15, 1'b1, 1'b0, 1'b0, 0, 0);
        run_phase(LEN_W'($urandom_range(12, 2)), PW_W'($urandom), 15,
                  1'b1, 1'b1, 1'b1, 46, 0);
        run_phase(9'd256, PW_W'($urandom), 15, 1'b0, 1'b0, 1'b1, 0, 46);

        wait_idle();
        if (fail_count == 0 && widths_due_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
